FILE: src/md5sh_pkg.sv
// md5sh_pkg: constants, tables and state type for the streaming md5 hasher
// no dependencies
package md5sh_pkg;

    localparam int unsigned BlockWords = 16;
    localparam int unsigned IdxW       = 4;
    localparam logic [31:0] PadByte    = 32'h0000_0080;

    localparam logic [31:0] InitA = 32'h6745_2301;
    localparam logic [31:0] InitB = 32'hefcd_ab89;
    localparam logic [31:0] InitC = 32'h98ba_dcfe;
    localparam logic [31:0] InitD = 32'h1032_5476;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    function automatic logic [31:0] step_const(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // message word used by round r
    function automatic logic [IdxW-1:0] msg_index(input logic [5:0] r);
        logic [7:0] rr;
        logic [7:0] g;
        begin
            rr = {2'b00, r};
            unique case (r[5:4])
                2'd0: g = rr;
                2'd1: g = 8'(rr * 8'd5 + 8'd1);
                2'd2: g = 8'(rr * 8'd3 + 8'd5);
                default: g = 8'(rr * 8'd7);
            endcase
            return g[IdxW-1:0];
        end
    endfunction

endpackage

FILE: src/md5sh_round.sv
// md5sh_round: one md5 step on the working words
// depends on md5sh_pkg
module md5sh_round
    import md5sh_pkg::*;
(
    input  logic [5:0]  i_round,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_m,
    output logic [31:0] o_b
);
    logic [31:0] f;
    logic [31:0] t;
    logic [4:0]  s;
    logic [63:0] rot;

    always_comb begin
        unique case (i_round[5:4])
            2'd0: f = (i_b & i_c) | (~i_b & i_d);
            2'd1: f = (i_b & i_d) | (i_c & ~i_d);
            2'd2: f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
        t   = i_a + f + i_m + step_const(i_round);
        s   = rot_amount(i_round);
        rot = {t, t} << s;
        o_b = i_b + rot[63:32];
    end
endmodule

FILE: src/md5_stream_hasher_unit.sv
// md5_stream_hasher_unit: streaming md5 hasher, top level
// depends on md5sh_pkg and md5sh_round
//
// channel | direction | fields                               | handshake
// input   | in        | data_word, byte_count, last_word     | i_in_valid / o_in_stall
// output  | out       | digest_low, digest_high              | o_out_valid / i_out_stall
//
// a word is written into the block memory on its transfer; a full block then
// runs 64 rounds (one round per cycle, the memory read registered the cycle
// before) and an add step, with the input stalled until it is done.
// a last word writes the pad words into the memory one per cycle while no block
// is hashed, one or two blocks, then holds the digest until its output transfer
// synchronous active-low reset; no clearing pass, the memory is always
// written before it is read
module md5_stream_hasher_unit
    import md5sh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_low,
    output logic [63:0] o_digest_high
);
    logic [31:0] r_mem [BlockWords];
    logic [31:0] r_mem_q;

    t_state      r_state, n_state;
    logic [IdxW-1:0] r_fill, n_fill;
    logic [5:0]  r_round, n_round;
    logic [63:0] r_len, n_len;
    logic [31:0] r_ch [4];
    logic [31:0] r_wk [4];
    logic [1:0]  r_pad, n_pad;    // 0 none, 1 zero fill, 2 length low, 3 length high
    logic        r_pending, n_pending;   // last word pad run in progress
    logic        r_extra, n_extra;       // pad byte still to go after a full last word
    logic [63:0] r_dlo, r_dhi;

    logic        wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [31:0] wr_data;
    logic [IdxW-1:0] rd_addr;
    logic [31:0] rnd_b;
    logic        in_xfer;
    logic [2:0]  cnt;
    logic [31:0] mask;
    logic [5:0]  bits;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_digest_low  = r_dlo;
    assign o_digest_high = r_dhi;

    md5sh_round u_round (
        .i_round (r_round),
        .i_a     (r_wk[0]),
        .i_b     (r_wk[1]),
        .i_c     (r_wk[2]),
        .i_d     (r_wk[3]),
        .i_m     (r_mem_q),
        .o_b     (rnd_b)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_round   = r_round;
        n_len     = r_len;
        n_pad     = r_pad;
        n_pending = r_pending;
        n_extra   = r_extra;
        wr_en     = 1'b0;
        wr_addr   = r_fill;
        wr_data   = 32'd0;
        rd_addr   = msg_index(6'd0);
        cnt       = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
        bits      = {cnt, 3'b000};
        mask      = (cnt == 3'd4) ? 32'hffff_ffff : ((32'd1 << bits[4:0]) - 32'd1);
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    wr_en = 1'b1;
                    if (!i_last_word) begin
                        wr_data = i_data_word;
                        n_len   = r_len + 64'd32;
                    end else begin
                        n_len     = r_len + {58'd0, bits};
                        n_pending = 1'b1;
                        n_pad     = 2'd1;
                        if (cnt == 3'd4) begin
                            wr_data = i_data_word;
                            n_extra = 1'b1;
                        end else begin
                            wr_data = (i_data_word & mask) | (PadByte << bits[4:0]);
                        end
                    end
                    n_fill = r_fill + 1'b1;
                    if (r_fill == IdxW'(BlockWords - 1)) begin
                        n_state = ST_ROUND;
                        n_round = 6'd0;
                    end else if (i_last_word) begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                // one pad word per cycle
                wr_en = 1'b1;
                if (r_extra) begin
                    wr_data = PadByte;
                    n_extra = 1'b0;
                end else if (r_pad == 2'd2
                             || (r_pad == 2'd1 && r_fill == IdxW'(BlockWords - 2))) begin
                    // pad word in slot 13 leaves no zero fill before the length
                    wr_data = r_len[31:0];
                    n_pad   = 2'd3;
                end else if (r_pad == 2'd1) begin
                    wr_data = 32'd0;
                    if (r_fill == IdxW'(BlockWords - 3)) n_pad = 2'd2;
                end else begin
                    wr_data = r_len[63:32];
                    n_pad   = 2'd0;
                end
                n_fill = r_fill + 1'b1;
                if (r_fill == IdxW'(BlockWords - 1)) begin
                    n_state = ST_ROUND;
                    n_round = 6'd0;
                end
            end
            ST_ROUND: begin
                rd_addr = msg_index(r_round + 6'd1);
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) n_state = ST_ADD;
            end
            ST_ADD: begin
                if (!r_pending) begin
                    n_state = ST_IDLE;
                end else if (r_extra || r_pad != 2'd0) begin
                    n_state = ST_PUSH;
                    // pad word in slot 14 or 15 or pad byte due: rest in a new block
                end else begin
                    n_state   = ST_OUT;
                    n_len     = '0;
                    n_pending = 1'b0;
                end
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_round   <= '0;
            r_len     <= '0;
            r_pad     <= 2'd0;
            r_pending <= 1'b0;
            r_extra   <= 1'b0;
            r_ch[0]   <= InitA;
            r_ch[1]   <= InitB;
            r_ch[2]   <= InitC;
            r_ch[3]   <= InitD;
            r_wk[0]   <= '0;
            r_wk[1]   <= '0;
            r_wk[2]   <= '0;
            r_wk[3]   <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_round   <= n_round;
            r_len     <= n_len;
            r_pad     <= n_pad;
            r_pending <= n_pending;
            r_extra   <= n_extra;
            if (n_state == ST_ROUND && r_state != ST_ROUND) begin
                r_wk[0] <= r_ch[0];
                r_wk[1] <= r_ch[1];
                r_wk[2] <= r_ch[2];
                r_wk[3] <= r_ch[3];
            end else if (r_state == ST_ROUND) begin
                r_wk[0] <= r_wk[3];
                r_wk[1] <= rnd_b;
                r_wk[2] <= r_wk[1];
                r_wk[3] <= r_wk[2];
            end
            if (r_state == ST_ADD) begin
                if (r_pending && !r_extra && r_pad == 2'd0) begin
                    r_ch[0]   <= InitA;
                    r_ch[1]   <= InitB;
                    r_ch[2]   <= InitC;
                    r_ch[3]   <= InitD;
                end else begin
                    r_ch[0] <= r_ch[0] + r_wk[0];
                    r_ch[1] <= r_ch[1] + r_wk[1];
                    r_ch[2] <= r_ch[2] + r_wk[2];
                    r_ch[3] <= r_ch[3] + r_wk[3];
                end
            end
        end
    end

    // digest capture from every add; the last add of a message gives its digest
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADD) begin
            r_dlo <= {r_ch[1] + r_wk[1], r_ch[0] + r_wk[0]};
            r_dhi <= {r_ch[3] + r_wk[3], r_ch[2] + r_wk[2]};
        end
    end
endmodule

FILE: tb/md5_stream_hasher_unit_tb.sv
// md5_stream_hasher_unit_tb: self-checking bench for the streaming md5 hasher
// depends on md5sh_pkg and the md5_stream_hasher_unit rtl
module md5_stream_hasher_unit_tb
    import md5sh_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] high;
    } t_digest;

    int mismatches;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    class digest_scoreboard;
        logic [31:0] msg_block[16];
        logic [31:0] chain[4];
        logic [63:0] bit_len;
        int unsigned fill;
        t_digest     pending[$];

        function void restart();
            chain[0] = InitA; chain[1] = InitB; chain[2] = InitC; chain[3] = InitD;
            bit_len = '0;
            fill    = 0;
        endfunction

        // floor(abs(sin(i + 1)) * 2^32), computed rather than tabulated
        function logic [31:0] sine_const(int r);
            real v;
            v = $sin(r + 1.0);
            if (v < 0.0)
                v = -v;
            return 32'(longint'(v * 4294967296.0 - 0.5));
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, f, t, k;
            int          g, s;
            int unsigned shifts[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                        6, 10, 15, 21};
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            for (int r = 0; r < 64; r++) begin
                if (r < 16) begin
                    f = (b & c) | (~b & d); g = r;
                end else if (r < 32) begin
                    f = (b & d) | (c & ~d); g = (5 * r + 1) % 16;
                end else if (r < 48) begin
                    f = b ^ c ^ d; g = (3 * r + 5) % 16;
                end else begin
                    f = c ^ (b | ~d); g = (7 * r) % 16;
                end
                k = sine_const(r);
                t = a + f + msg_block[g] + k;
                s = shifts[(r / 16) * 4 + (r % 4)];
                a = d; d = c; c = b;
                b = b + ((t << s) | (t >> (32 - s)));
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        endfunction

        function void push(logic [31:0] w);
            msg_block[fill] = w;
            fill++;
            if (fill == 16) begin
                compress();
                fill = 0;
            end
        endfunction

        function void note_word(logic [31:0] data, logic [2:0] cnt, logic last);
            int unsigned n;
            if (!last) begin
                bit_len += 64'd32;
                push(data);
                return;
            end
            n = (cnt > 4) ? 4 : cnt;
            bit_len += 64'(8 * n);
            if (n == 4) begin
                push(data);
                push(PadByte);
            end else begin
                push((data & ((32'd1 << (8 * n)) - 1)) | (PadByte << (8 * n)));
            end
            if (fill > 14)
                while (fill != 0)
                    push('0);
            while (fill < 14)
                push('0);
            push(bit_len[31:0]);
            push(bit_len[63:32]);
            pending.push_back('{low: {chain[1], chain[0]}, high: {chain[3], chain[2]}});
            restart();
        endfunction

        task check_digest(logic [63:0] low, logic [63:0] high);
            t_digest want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected digest %h_%h", high, low));
                return;
            end
            want = pending.pop_front();
            if (low !== want.low)
                report_mismatch($sformatf("digest_low %h, want %h", low, want.low));
            if (high !== want.high)
                report_mismatch($sformatf("digest_high %h, want %h", high, want.high));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_data_word = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last_word = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [63:0] o_digest_low;
    logic [63:0] o_digest_high;

    int               send_gap_pct;
    int               recv_stall_pct;
    digest_scoreboard hash_sb;

    md5_stream_hasher_unit i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // one word transfer, with random idle cycles before it
    task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_word  <= data;
        i_byte_count <= cnt;
        i_last_word  <= last;
        do
            @(posedge i_clk);
        while (o_in_stall);
        hash_sb.note_word(data, cnt, last);
    endtask

    // message of nwords full words then a tail word of tail bytes
    task automatic send_message(int nwords, logic [2:0] tail);
        for (int i = 0; i < nwords; i++)
            send_word($urandom(), 3'($urandom_range(7)), 1'b0);
        send_word($urandom(), tail, 1'b1);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (hash_sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            hash_sb.check_digest(o_digest_low, o_digest_high);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int n;
        hash_sb = new();
        hash_sb.restart();
        send_gap_pct   = 13;
        recv_stall_pct = 55;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, tail sizes 0 to 4 and 7, boundaries around the pad
        send_word(32'hffff_ffff, 3'd0, 1'b1);
        send_word(32'h0063_6261, 3'd3, 1'b1);
        send_word(32'hffff_ffff, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        send_word(32'h0000_0000, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        send_message(12, 3'd4);
        send_message(13, 3'd3);
        send_message(13, 3'd4);
        send_message(14, 3'd0);
        send_message(15, 3'd4);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 13 : (phase == 1) ? 55 : 0;
            recv_stall_pct = (phase == 0) ? 55 : (phase == 1) ? 13 : 0;
            n = 0;
            while (n < 170) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(40)
                                               : $urandom_range(17);
                send_message(len, 3'($urandom_range(7)));
                n += len + 1;
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
